FILE: src/alm_pkg.sv
// Shared types, codes and defaults for the array linked list manager.
`timescale 1ns / 1ps

package alm_pkg;

  localparam int CELLS_DEF = 256;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } stat_t;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cell_index;
    logic [7:0] item_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;  // init one store entry, advance sweep index
    logic cap;  // capture input beat
    logic rd;   // read link/free stores at captured position and free head
    logic ex;   // check, first link writes, head/count update
    logic wb;   // second link writes, load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

FILE: src/alm_ctrl.sv
// Sequencer for the array linked list manager: init sweep, op phases, result handshake.
`timescale 1ns / 1ps

module alm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  alm_pkg::dp_stat_t    stat,
  output alm_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_EX,
    S_WB
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load  = !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.ex    = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (can_load) begin
          cmd.wb        = 1'b1;
          out_valid_nxt = 1'b1;
          in_stall      = 1'b0;
          if (in_valid) begin
            cmd.cap   = 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/alm_dp.sv
// Datapath for the array linked list manager: cell stores, free head, live count, result.
`timescale 1ns / 1ps

module alm_dp #(
  parameter int CELLS = alm_pkg::CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alm_pkg::ctrl_cmd_t   cmd,
  output alm_pkg::dp_stat_t    stat,
  input  alm_pkg::in_item_t    in_data,
  output alm_pkg::out_item_t   out_data
);

  localparam int IW = $clog2(CELLS);

  // cell stores
  logic [IW-1:0] next_mem [CELLS];
  logic [IW-1:0] prev_mem [CELLS];
  logic          free_mem [CELLS];
  logic [31:0]   val_mem  [CELLS];

  // captured beat
  logic        op_r;
  logic [7:0]  pos_r;
  logic [31:0] val_r;

  logic [IW-1:0] clr_idx_r;
  logic [IW-1:0] free_head_r;
  logic [IW-1:0] live_r;

  // registered read data
  logic [IW-1:0] nxt_a_r;   // next of position
  logic [IW-1:0] nxt_b_r;   // next of free head
  logic [IW-1:0] prv_r;     // prev of position
  logic          free_rd_r;

  logic [1:0]    status_r;
  logic [IW-1:0] cell_r;
  alm_pkg::out_item_t out_data_r;

  logic [IW-1:0] pos_idx;
  logic          pos_ok;
  logic          is_ins;
  logic          full;
  logic [1:0]    ex_status;
  logic          ex_ok;
  logic          wb_ok;

  logic          nx_we, pv_we, fr_we, vl_we;
  logic [IW-1:0] nx_wa, pv_wa, fr_wa, vl_wa;
  logic [IW-1:0] nx_wd, pv_wd;
  logic          fr_wd;

  assign pos_idx = IW'(pos_r);
  assign pos_ok  = int'(pos_r) < CELLS;
  assign is_ins  = (op_r == alm_pkg::OP_INSERT);
  assign full    = (live_r == IW'(CELLS - 1));
  assign stat.clr_last = (clr_idx_r == IW'(CELLS - 1));

  // full takes precedence over a bad position on insert
  always_comb begin
    if (is_ins) begin
      if (full) begin
        ex_status = alm_pkg::ST_FULL;
      end else if (!pos_ok || free_rd_r) begin
        ex_status = alm_pkg::ST_BAD;
      end else begin
        ex_status = alm_pkg::ST_OK;
      end
    end else begin
      if (pos_r == 8'd0 || !pos_ok || free_rd_r) begin
        ex_status = alm_pkg::ST_BAD;
      end else begin
        ex_status = alm_pkg::ST_OK;
      end
    end
  end

  assign ex_ok = cmd.ex && (ex_status == alm_pkg::ST_OK);
  assign wb_ok = cmd.wb && (status_r == alm_pkg::ST_OK);

  // Write ports. Insert: new cell spliced between pos and after (= next of pos).
  // Delete: neighbors joined, cell pushed on free list.
  always_comb begin
    nx_we = 1'b0;
    nx_wa = clr_idx_r;
    nx_wd = '0;
    pv_we = 1'b0;
    pv_wa = clr_idx_r;
    pv_wd = '0;
    fr_we = 1'b0;
    fr_wa = clr_idx_r;
    fr_wd = 1'b0;
    vl_we = 1'b0;
    vl_wa = free_head_r;
    if (cmd.clr) begin
      nx_we = 1'b1;
      if (clr_idx_r == '0 || clr_idx_r == IW'(CELLS - 1)) begin
        nx_wd = '0;
      end else begin
        nx_wd = clr_idx_r + IW'(1);
      end
      pv_we = 1'b1;
      fr_we = 1'b1;
      fr_wd = (clr_idx_r != '0);
    end else if (ex_ok) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      fr_we = 1'b1;
      pv_wa = nxt_a_r;
      if (is_ins) begin
        nx_wa = free_head_r;
        nx_wd = nxt_a_r;
        pv_wd = free_head_r;
        fr_wa = free_head_r;
        fr_wd = 1'b0;
        vl_we = 1'b1;
      end else begin
        nx_wa = pos_idx;
        nx_wd = free_head_r;
        pv_wd = prv_r;
        fr_wa = pos_idx;
        fr_wd = 1'b1;
      end
    end else if (wb_ok) begin
      nx_we = 1'b1;
      if (is_ins) begin
        nx_wa = pos_idx;
        nx_wd = cell_r;
        pv_we = 1'b1;
        pv_wa = cell_r;
        pv_wd = pos_idx;
      end else begin
        nx_wa = prv_r;
        nx_wd = nxt_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (fr_we) begin
      free_mem[fr_wa] <= fr_wd;
    end
    if (vl_we) begin
      val_mem[vl_wa] <= val_r;
    end
    if (cmd.rd) begin
      nxt_a_r   <= next_mem[pos_idx];
      nxt_b_r   <= next_mem[free_head_r];
      prv_r     <= prev_mem[pos_idx];
      free_rd_r <= free_mem[pos_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      val_r <= in_data.value;
    end
    if (cmd.ex) begin
      status_r <= ex_status;
      cell_r   <= is_ins ? free_head_r : pos_idx;
    end
    if (cmd.wb) begin
      out_data_r.status     <= status_r;
      out_data_r.cell_index <= (status_r == alm_pkg::ST_OK) ? 8'(cell_r) : 8'd0;
      out_data_r.item_count <= 8'(live_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      free_head_r <= IW'(1);
      live_r      <= '0;
    end else begin
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + IW'(1);
      end
      if (ex_ok) begin
        if (is_ins) begin
          free_head_r <= nxt_b_r;
          live_r      <= live_r + IW'(1);
        end else begin
          free_head_r <= pos_idx;
          if (live_r != '0) begin
            live_r <= live_r - IW'(1);
          end
        end
      end
    end
  end

  assign out_data = out_data_r;

endmodule

FILE: src/array_linked_list_manager_top.sv
// Top level of the array linked list manager: sequencer plus datapath.
//
//   channel  | dir | ports                           | beat
//   ---------+-----+---------------------------------+-------------------------------
//   in       | in  | in_valid, in_stall, in_data     | opcode, position, value
//   out      | out | out_valid, out_stall, out_data  | status, cell_index, item_count
//
// Each operation runs in phases: read of the link stores, check and first link
// writes, second link writes; the single write port of the next-link store sets this.
// After reset an init sweep writes the link and free stores with in_stall high.
// The result sits in an output register; the next beat is taken while it waits,
// and a stalled result holds the op in its last phase until it can be loaded.
`timescale 1ns / 1ps

module array_linked_list_manager_top #(
  parameter int CELLS = alm_pkg::CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  alm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output alm_pkg::out_item_t  out_data
);

  alm_pkg::ctrl_cmd_t cmd;
  alm_pkg::dp_stat_t  stat;

  alm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  alm_dp #(
    .CELLS (CELLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the array linked list manager.
`timescale 1ns / 1ps

module tb_top;

  localparam int NCELL = alm_pkg::CELLS_DEF;

  // Mirror of the list store; predicts the result beat of each accepted op.
  class list_scoreboard;
    bit [7:0]    nxt_cell [NCELL];
    bit [7:0]    prv_cell [NCELL];
    bit          vacant [NCELL];
    bit [7:0]    free_top;
    int unsigned live_cells;
    alm_pkg::out_item_t pending_results [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < NCELL; i++) begin
        nxt_cell[i] = (i + 1 < NCELL) ? 8'(i + 1) : 8'd0;
        prv_cell[i] = 8'd0;
        vacant[i]   = 1'b1;
      end
      nxt_cell[0] = 8'd0;
      vacant[0]   = 1'b0;
      free_top    = 8'd1;
      live_cells  = 0;
      errors      = 0;
    endfunction

    // Updates the list and returns the result beat the op must produce.
    function alm_pkg::out_item_t apply_op(alm_pkg::in_item_t op_beat);
      alm_pkg::out_item_t res;
      bit [7:0]  p;
      bit [7:0]  c;
      bit [7:0]  after;
      bit [7:0]  nx;
      bit [7:0]  pv;
      p = op_beat.position;
      res.status = alm_pkg::ST_OK;
      res.cell_index = 8'd0;
      if (op_beat.opcode == alm_pkg::OP_INSERT) begin
        // full check wins over the position check
        if (live_cells >= NCELL - 1) begin
          res.status = alm_pkg::ST_FULL;
        end else if (vacant[p]) begin
          res.status = alm_pkg::ST_BAD;
        end else begin
          c = free_top;
          free_top = nxt_cell[c];
          after = nxt_cell[p];
          prv_cell[after] = c;
          nxt_cell[c] = after;
          prv_cell[c] = p;
          nxt_cell[p] = c;
          vacant[c] = 1'b0;
          live_cells++;
          res.cell_index = c;
        end
      end else begin
        if (p == 8'd0 || vacant[p]) begin
          res.status = alm_pkg::ST_BAD;
        end else begin
          nx = nxt_cell[p];
          pv = prv_cell[p];
          prv_cell[nx] = pv;
          nxt_cell[pv] = nx;
          nxt_cell[p] = free_top;
          vacant[p] = 1'b1;
          free_top = p;
          if (live_cells > 0) live_cells--;
          res.cell_index = p;
        end
      end
      res.item_count = 8'(live_cells);
      return res;
    endfunction

    function void note_op(alm_pkg::in_item_t op_beat);
      pending_results.push_back(apply_op(op_beat));
    endfunction

    function void check_result(alm_pkg::out_item_t got);
      alm_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d cell %0d count %0d",
                 $time, got.status, got.cell_index, got.item_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.cell_index !== want.cell_index ||
          got.item_count !== want.item_count) begin
        errors++;
        $display("%0t: mismatch: expected status %0d cell %0d count %0d,",
                 $time, want.status, want.cell_index, want.item_count,
                 " got status %0d cell %0d count %0d",
                 got.status, got.cell_index, got.item_count);
      end
    endfunction

    // Random live cell; the sentinel only when allowed. Falls back to noise.
    function bit [7:0] pick_live(bit allow_sentinel);
      int unsigned start;
      int unsigned idx;
      start = $urandom_range(NCELL - 1);
      for (int k = 0; k < NCELL; k++) begin
        idx = (start + k) % NCELL;
        if (!vacant[idx] && (allow_sentinel || idx != 0)) return 8'(idx);
      end
      return 8'($urandom_range(NCELL - 1));
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  alm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  alm_pkg::out_item_t out_data;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  list_scoreboard sb = new();

  array_linked_list_manager_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic alm_pkg::in_item_t mk_op(alm_pkg::op_t op, bit [7:0] pos,
                                              logic [31:0] val);
    alm_pkg::in_item_t b;
    b.opcode = op;
    b.position = pos;
    b.value = val;
    return b;
  endfunction

  // ins_pct sets the insert/delete mix; most positions name live cells.
  function automatic alm_pkg::in_item_t rand_op(int unsigned ins_pct);
    alm_pkg::in_item_t b;
    alm_pkg::op_t      op;
    op = ($urandom_range(99) < ins_pct) ? alm_pkg::OP_INSERT : alm_pkg::OP_DELETE;
    b.opcode = op;
    b.value = $urandom();
    if ($urandom_range(99) < 80) b.position = sb.pick_live(op == alm_pkg::OP_INSERT);
    else b.position = 8'($urandom_range(NCELL - 1));
    return b;
  endfunction

  // Called right after clk rises; returns once the beat has been taken.
  task automatic send_op(alm_pkg::in_item_t b);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_op(b);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Result side: random stall, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (hold_req && !hold_done) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 32);
      end
    end
  end

  initial begin : stimulus
    int unsigned mix;
    int unsigned len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad positions on an empty list, value extremes, reuse of freed cells
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd0, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd5, 32'h0));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd9, 32'h1234_5678));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd0, 32'h7FFF_FFFF));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd0, 32'h8000_0000));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd1, 32'h0));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd255, 32'hFFFF_FFFF));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd3, 32'hFFFF_FFFF));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd255, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd2, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd2, 32'h0));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd0, 32'h1));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd2, 32'h5555_5555));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd4, 32'hAAAA_AAAA));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd1, 32'hFFFF_FFFF));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd4, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd6, 32'h0));
    send_op(mk_op(alm_pkg::OP_INSERT, 8'd5, 32'hDEAD_BEEF));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd2, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd3, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd5, 32'h0));
    send_op(mk_op(alm_pkg::OP_DELETE, 8'd6, 32'h0));
    drain_results();

    // grow to full, drain to empty, mixed, grow again, drain
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          mix = 85;
          len = 450;
        end
        1: begin
          mix = 15;
          len = 400;
        end
        2: begin
          mix = 50;
          len = 300;
        end
        3: begin
          mix = 90;
          len = 400;
        end
        default: begin
          mix = 10;
          len = 300;
        end
      endcase
      if (ph == 3) drain_results();
      for (int k = 0; k < len; k++) begin
        if (ph == 0 && k == 40) hold_req = 1'b1;
        no_idle = (ph == 2 && k >= 60 && k < 260);
        send_op(rand_op(mix));
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time,
               sb.pending_results.size());
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: array_linked_list_manager_top.f
src/alm_pkg.sv
src/alm_ctrl.sv
src/alm_dp.sv
src/array_linked_list_manager_top.sv
sim/tb_top.sv
